[sv/cnf_pkg.sv]
`default_nettype none

package cnf_pkg;

    // Request codes carried on the operation field.
    typedef enum logic [1:0] {
        OP_RAW   = 2'd0,
        OP_HEX32 = 2'd1,
        OP_HEX64 = 2'd2,
        OP_DEC   = 2'd3
    } op_t;

    // Widths of the decimal path.
    localparam int unsigned BIN_W      = 32;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * DEC_DIGITS;

    // ASCII codes used by the formatter.
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_X    = 8'h78;

    // Uppercase hex character for one nibble; decimal digits use the same map.
    function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
        logic [7:0] wide;
        wide = {4'h0, nibble};
        if (nibble < 4'd10) begin
            return ASCII_ZERO + wide;
        end
        return 8'h37 + wide;
    endfunction

endpackage

`default_nettype wire

[sv/console_number_formatter.sv]
`default_nettype none

// Formats one print request into the ASCII bytes of a console line, one byte
// per output transaction, with m_last on the final byte. A raw character is
// sent as it is, but a line feed is preceded by a carriage return. Hex32
// sends "0x" and 8 digits and hex64 sends "0x" and 16 digits, one byte per
// cycle from a nibble shift register while the output register is free. A
// decimal request is accepted, then goes through the shift-add-3 converter,
// which moves in one binary bit per shift and then raises its done flag, and
// then through a state that drops leading zeros and one that sends digits.
// With the output never stalled it takes the same time whatever its value.
// Each byte also waits while the output register is still full. A new request
// is taken only when the previous one has produced its last byte; that byte
// may still be waiting in the output register.
module console_number_formatter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last
);
    import cnf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW_CR,
        ST_RAW_CHAR,
        ST_PFX_ZERO,
        ST_PFX_X,
        ST_CONV,
        ST_SKIP,
        ST_DIGITS
    } state_t;

    localparam logic [4:0] HEX32_DIGITS = 5'd8;
    localparam logic [4:0] HEX64_DIGITS = 5'd16;
    localparam logic [4:0] DEC_COUNT    = 5'(DEC_DIGITS);

    state_t      state_reg, state_next;
    logic [63:0] nib_reg, nib_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  char_reg, char_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;

    logic             out_free;
    logic             conv_start;
    logic             conv_done;
    logic [BCD_W-1:0] conv_bcd;

    // Serial binary to BCD converter for decimal requests.
    cnf_bcd_conv u_bcd_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .bin_in  (s_value[BIN_W-1:0]),
        .done    (conv_done),
        .bcd_out (conv_bcd)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: loads a request, then walks its bytes into the output register.
    always_comb begin
        state_next   = state_reg;
        nib_next     = nib_reg;
        cnt_next     = cnt_reg;
        char_next    = char_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        conv_start   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (op_t'(s_operation))
                        OP_RAW: begin
                            char_next = s_value[7:0];
                            if (s_value[7:0] == ASCII_LF) begin
                                state_next = ST_RAW_CR;
                            end else begin
                                state_next = ST_RAW_CHAR;
                            end
                        end
                        OP_HEX32: begin
                            nib_next   = {s_value[31:0], 32'h0};
                            cnt_next   = HEX32_DIGITS;
                            state_next = ST_PFX_ZERO;
                        end
                        OP_HEX64: begin
                            nib_next   = s_value;
                            cnt_next   = HEX64_DIGITS;
                            state_next = ST_PFX_ZERO;
                        end
                        default: begin
                            conv_start = 1'b1;
                            state_next = ST_CONV;
                        end
                    endcase
                end
            end
            ST_RAW_CR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ASCII_CR;
                    m_last_next  = 1'b0;
                    state_next   = ST_RAW_CHAR;
                end
            end
            ST_RAW_CHAR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = char_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PFX_ZERO: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ASCII_ZERO;
                    m_last_next  = 1'b0;
                    state_next   = ST_PFX_X;
                end
            end
            ST_PFX_X: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ASCII_X;
                    m_last_next  = 1'b0;
                    state_next   = ST_DIGITS;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    nib_next   = {conv_bcd, 24'h0};
                    cnt_next   = DEC_COUNT;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits, always keeping the last one.
                if (nib_reg[63:60] == 4'h0 && cnt_reg != 5'd1) begin
                    nib_next = {nib_reg[59:0], 4'h0};
                    cnt_next = cnt_reg - 5'd1;
                end else begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = hex_ascii(nib_reg[63:60]);
                    m_last_next  = (cnt_reg == 5'd1);
                    nib_next     = {nib_reg[59:0], 4'h0};
                    cnt_next     = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        nib_reg    <= nib_next;
        cnt_reg    <= cnt_next;
        char_reg   <= char_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

[sv/cnf_bcd_conv.sv]
`default_nettype none

module cnf_bcd_conv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cnf_pkg::BIN_W-1:0]   bin_in,
    output logic                             done,
    output logic [cnf_pkg::BCD_W-1:0]        bcd_out
);
    import cnf_pkg::*;

    localparam int unsigned CNT_W = $clog2(BIN_W);

    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] bcd_adj;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // One binary bit moves into the BCD register per cycle.
    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        active_next  = active_reg;
        done_next    = 1'b0;
        if (start) begin
            bin_next     = bin_in;
            bcd_next     = '0;
            bit_cnt_next = CNT_W'(BIN_W - 1);
            active_next  = 1'b1;
        end else if (active_reg) begin
            bin_next     = {bin_reg[BIN_W-2:0], 1'b0};
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bit_cnt_next = bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    assign done    = done_reg;
    assign bcd_out = bcd_reg;

endmodule

`default_nettype wire

[sv/cnf_checker.sv]
`default_nettype none

module cnf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_operation,
    input wire logic [63:0] s_value,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_out_byte,
    input wire logic        m_last
);

    // A stalled output transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
    else $error("output payload changed while stalled");

    // Once a request is taken the block is not ready in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
    else $error("request taken twice in consecutive cycles");

    // No new request is taken while the current one still has bytes to send.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
    else $error("ready while a request is only partly sent");

    // A carriage return inserted before a line feed is followed at once by it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last && m_out_byte == 8'h0D
        |=> m_valid && m_last && m_out_byte == 8'h0A)
    else $error("carriage return not followed by line feed");

endmodule

bind console_number_formatter cnf_checker u_cnf_checker (.*);

`default_nettype wire

[tb/console_number_formatter_tb.sv]
`timescale 1ns / 100ps

module console_number_formatter_tb;

    import cnf_pkg::*;

    // One print request as the sender presents it.
    typedef struct {
        op_t         op;
        logic [63:0] value;
    } print_req_t;

    // One byte the transmitter should receive.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_byte_t;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_PER_PHASE = 160;
    localparam int unsigned DRAIN_CYCLES = 120;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [63:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;

    print_req_t  print_reqs[$];
    tx_byte_t    tx_bytes_due[$];
    int unsigned send_idle_pct = 10;
    int unsigned recv_stall_pct = 75;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    console_number_formatter u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

    always #6 aclk = ~aclk;

    // Appends the bytes a request should produce, in transmit order.
    function automatic void format_request(input op_t op, input logic [63:0] value);
        logic [7:0]  chars[$];
        logic [7:0]  rev[10];
        logic [3:0]  nib;
        logic [31:0] n;
        int          digits;
        int          cnt;
        tx_byte_t    tb;
        chars = {};
        cnt = 0;
        case (op)
            OP_RAW: begin
                if (value[7:0] == ASCII_LF) begin
                    chars.push_back(ASCII_CR);
                end
                chars.push_back(value[7:0]);
            end
            OP_HEX32, OP_HEX64: begin
                digits = (op == OP_HEX32) ? 8 : 16;
                chars.push_back(ASCII_ZERO);
                chars.push_back(ASCII_X);
                for (int k = digits - 1; k >= 0; k--) begin
                    nib = value[k * 4 +: 4];
                    chars.push_back((nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10);
                end
            end
            default: begin
                n = value[31:0];
                if (n == 0) begin
                    chars.push_back(ASCII_ZERO);
                end
                while (n != 0) begin
                    rev[cnt] = ASCII_ZERO + 8'(n % 10);
                    n = n / 10;
                    cnt++;
                end
                for (int k = cnt - 1; k >= 0; k--) begin
                    chars.push_back(rev[k]);
                end
            end
        endcase
        foreach (chars[i]) begin
            tb.data = chars[i];
            tb.last = (i == chars.size() - 1);
            tx_bytes_due.push_back(tb);
        end
    endfunction

    task automatic add_req(input op_t op, input logic [63:0] value);
        print_req_t r;
        r.op = op;
        r.value = value;
        print_reqs.push_back(r);
    endtask

    // Driver: presents queued requests, idling at random between transactions.
    always @(posedge aclk) begin
        print_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                format_request(op_t'(s_operation), s_value);
            end
            if (!s_valid || s_ready) begin
                if (print_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = print_reqs.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= r.op;
                    s_value     <= r.value;
                end else begin
                    s_valid     <= 1'b0;
                    s_operation <= 2'($urandom);
                    s_value     <= {$urandom, $urandom};
                end
            end
        end
    end

    // Monitor: checks each received byte against the oldest expected one.
    always @(posedge aclk) begin
        tx_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tx_bytes_due.size() == 0) begin
                    $error("unexpected byte 0x%02h (last %0b) with nothing pending",
                           m_out_byte, m_last);
                    mismatches++;
                end else begin
                    want = tx_bytes_due.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, m_out_byte);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_last);
                        mismatches++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a long stretch with no transaction on either side means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        op_t         op;
        logic [63:0] v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: field extremes and the special cases.
        add_req(OP_RAW,   64'h0);
        add_req(OP_RAW,   64'hFF);
        add_req(OP_RAW,   64'h0A);
        add_req(OP_RAW,   64'hFFFF_FFFF_FFFF_FF0A);
        add_req(OP_RAW,   64'hFFFF_FFFF_FFFF_FF41);
        add_req(OP_RAW,   64'h0D);
        add_req(OP_HEX32, 64'h0);
        add_req(OP_HEX32, 64'hFFFF_FFFF);
        add_req(OP_HEX32, 64'hDEAD_BEEF_1234_5678);
        add_req(OP_HEX64, 64'h0);
        add_req(OP_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(OP_HEX64, 64'h0123_4567_89AB_CDEF);
        add_req(OP_DEC,   64'h0);
        add_req(OP_DEC,   64'hFFFF_FFFF_0000_0000);
        add_req(OP_DEC,   64'd1);
        add_req(OP_DEC,   64'd9);
        add_req(OP_DEC,   64'd10);
        add_req(OP_DEC,   64'd4294967295);
        add_req(OP_DEC,   64'd1000000000);
        add_req(OP_DEC,   64'd999999999);
        add_req(OP_DEC,   64'hFFFF_FFFF_0000_002A);

        // Three idling patterns: slow receiver, slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 75;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                op = op_t'($urandom_range(3));
                v = {$urandom, $urandom};
                // Shifting spreads decimal lengths and leaves many zero digits.
                if ($urandom_range(2) == 0) begin
                    v = v >> $urandom_range(63);
                end
                if (op == OP_RAW && $urandom_range(5) == 0) begin
                    v[7:0] = ASCII_LF;
                end
                add_req(op, v);
            end
            while (print_reqs.size() != 0 || s_valid || tx_bytes_due.size() != 0) begin
                @(posedge aclk);
            end
        end

        // Let any stray bytes show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && tx_bytes_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
sv/cnf_pkg.sv
sv/cnf_bcd_conv.sv
sv/console_number_formatter.sv
sv/cnf_checker.sv
tb/console_number_formatter_tb.sv
